### rtl/core/slr_pkg.sv
`timescale 1ns / 1ps

package slr_pkg;

  // Internal coordinate width: the widest value the top-level COORD_BITS may take.
  localparam int COORD_MAX_BITS = 6;
  localparam int CENTER_BITS    = 6;
  localparam int PIX_BITS       = 8;
  localparam int CFG_IDX_BITS   = 2;
  localparam int REM_BITS       = COORD_MAX_BITS + 3;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [CENTER_BITS-1:0]  CENTER_RESET = 6'd32;

  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y = 2'd1;

  typedef logic signed [COORD_MAX_BITS-1:0] coord_t;
  typedef logic signed [COORD_MAX_BITS:0]   diff_t;
  typedef logic [COORD_MAX_BITS-1:0]        steps_t;
  typedef logic [COORD_MAX_BITS:0]          twom_t;
  typedef logic signed [COORD_MAX_BITS+1:0] dmin2_t;
  typedef logic signed [REM_BITS-1:0]       rem_t;
  typedef logic [CENTER_BITS-1:0]           center_t;
  typedef logic signed [PIX_BITS-1:0]       pix_t;
  typedef logic [CFG_IDX_BITS-1:0]          cfg_idx_t;

  // One classified segment, as handed from the front end to the stepper.
  typedef struct packed {
    coord_t major_start;
    coord_t minor_start;
    logic   x_major;
    logic   major_neg;
    steps_t steps;
    dmin2_t dminor2;
  } seg_desc_t;

  // Queue handshake seen by the stepper.
  typedef struct packed {
    logic      valid;
    seg_desc_t desc;
  } queue_out_t;

endpackage

### rtl/core/slr_ifs.sv
`timescale 1ns / 1ps

interface slr_seg_if #(
  parameter int COORD_BITS = 6
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface slr_pix_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] pixel_column;
  logic signed [7:0] pixel_row;
  logic              last_pixel;

  modport source (output valid, pixel_column, pixel_row, last_pixel, input ready);
  modport sink   (input valid, pixel_column, pixel_row, last_pixel, output ready);
endinterface

interface slr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [5:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/slope_line_rasterizer.sv
// After the segment transaction is accepted, it is held in the queue, then loaded into
// the stepper's state registers, and its first pixel goes to the stepper's output register.
// Throughput: one pixel per cycle while out_ch.ready holds, at most 64 pixels per segment;
// the stepper's single pixel step per cycle sets this, and a two-entry queue keeps
// accepting segments while it works. Reset (rst_n low, synchronous) empties the queue,
// idles the stepper and the output, and sets center_x and center_y to 32.
`timescale 1ns / 1ps

module slope_line_rasterizer
  import slr_pkg::*;
#(
  parameter int COORD_BITS = 6
) (
  input  logic      clk,
  input  logic      rst_n,
  slr_cfg_if.sink   cfg_ch,
  slr_seg_if.sink   in_ch,
  slr_pix_if.source out_ch
);

  center_t    center_x_r, center_x_nxt;
  center_t    center_y_r, center_y_nxt;
  logic       push_valid, push_ready, pop_en;
  seg_desc_t  push_desc;
  queue_out_t head;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    center_x_nxt = center_x_r;
    center_y_nxt = center_y_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_CENTER_X: center_x_nxt = cfg_ch.data;
        REG_CENTER_Y: center_y_nxt = cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= CENTER_RESET;
      center_y_r <= CENTER_RESET;
    end else begin
      center_x_r <= center_x_nxt;
      center_y_r <= center_y_nxt;
    end
  end

  slr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .in_ch      (in_ch),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_desc  (push_desc)
  );

  slr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_desc  (push_desc),
    .push_ready (push_ready),
    .pop_en     (pop_en),
    .head       (head)
  );

  slr_stepper u_stepper (
    .clk      (clk),
    .rst_n    (rst_n),
    .center_x (center_x_r),
    .center_y (center_y_r),
    .head     (head),
    .pop_en   (pop_en),
    .out_ch   (out_ch)
  );

endmodule

### rtl/core/slr_front.sv
`timescale 1ns / 1ps

module slr_front
  import slr_pkg::*;
#(
  parameter int COORD_BITS = 6
) (
  slr_seg_if.sink   in_ch,
  input  logic      push_ready,
  output logic      push_valid,
  output seg_desc_t push_desc
);

  coord_t sx, sy, ex, ey;
  diff_t  dx, dy;
  steps_t adx, ady;
  logic   x_major;

  // Only the low COORD_BITS bits of each coordinate carry the value.
  assign sx = coord_t'($signed(in_ch.start_x[COORD_BITS-1:0]));
  assign sy = coord_t'($signed(in_ch.start_y[COORD_BITS-1:0]));
  assign ex = coord_t'($signed(in_ch.end_x[COORD_BITS-1:0]));
  assign ey = coord_t'($signed(in_ch.end_y[COORD_BITS-1:0]));

  assign dx = diff_t'(ex) - diff_t'(sx);
  assign dy = diff_t'(ey) - diff_t'(sy);

  assign adx = dx[COORD_MAX_BITS] ? steps_t'(-dx) : steps_t'(dx);
  assign ady = dy[COORD_MAX_BITS] ? steps_t'(-dy) : steps_t'(dy);

  // The x axis wins a tie.
  assign x_major = (adx >= ady);

  always_comb begin
    push_desc.x_major     = x_major;
    push_desc.major_start = x_major ? sx : sy;
    push_desc.minor_start = x_major ? sy : sx;
    push_desc.major_neg   = x_major ? dx[COORD_MAX_BITS] : dy[COORD_MAX_BITS];
    push_desc.steps       = x_major ? adx : ady;
    push_desc.dminor2     = x_major ? dmin2_t'({dy, 1'b0}) : dmin2_t'({dx, 1'b0});
  end

  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

endmodule

### rtl/core/slr_queue.sv
`timescale 1ns / 1ps

module slr_queue
  import slr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  input  seg_desc_t  push_desc,
  output logic       push_ready,
  input  logic       pop_en,
  output queue_out_t head
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef logic [PTR_BITS-1:0] ptr_t;
  typedef logic [CNT_BITS-1:0] cnt_t;

  seg_desc_t entry_r [QUEUE_DEPTH];
  ptr_t      wr_ptr_r, wr_ptr_nxt;
  ptr_t      rd_ptr_r, rd_ptr_nxt;
  cnt_t      count_r, count_nxt;
  logic      push, pop;

  assign push_ready = (count_r != cnt_t'(QUEUE_DEPTH));
  assign push       = push_valid && push_ready;
  assign pop        = pop_en && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.desc  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + ptr_t'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + ptr_t'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + cnt_t'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

### rtl/core/slr_stepper.sv
`timescale 1ns / 1ps

module slr_stepper
  import slr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  center_t    center_x,
  input  center_t    center_y,
  input  queue_out_t head,
  output logic       pop_en,
  slr_pix_if.source  out_ch
);

  logic   active_r, active_nxt;
  logic   out_valid_r, out_valid_nxt;
  coord_t maj_r, maj_nxt;
  coord_t min_r, min_nxt;
  rem_t   rem_r, rem_nxt;
  steps_t left_r, left_nxt;
  logic   xmaj_r, xmaj_nxt;
  logic   neg_r, neg_nxt;
  dmin2_t dmin2_r, dmin2_nxt;
  twom_t  twom_r, twom_nxt;
  pix_t   col_r, col_nxt;
  pix_t   row_r, row_nxt;
  logic   last_r, last_nxt;

  logic   fire, is_last;
  rem_t   rem_sum, twom_ext;
  coord_t cur_x, cur_y;

  assign fire    = active_r && (!out_valid_r || out_ch.ready);
  assign is_last = (left_r == '0);
  assign pop_en  = head.valid && (!active_r || (fire && is_last));

  // The remainder tracks (2*d_minor*k + M) mod 2M, so one signed step keeps the
  // rounded minor coordinate exact with at most one correction per pixel.
  assign rem_sum  = rem_r + rem_t'(dmin2_r);
  assign twom_ext = rem_t'($signed({1'b0, twom_r}));

  assign cur_x = xmaj_r ? maj_r : min_r;
  assign cur_y = xmaj_r ? min_r : maj_r;

  always_comb begin
    active_nxt    = active_r;
    out_valid_nxt = out_valid_r;
    maj_nxt       = maj_r;
    min_nxt       = min_r;
    rem_nxt       = rem_r;
    left_nxt      = left_r;
    xmaj_nxt      = xmaj_r;
    neg_nxt       = neg_r;
    dmin2_nxt     = dmin2_r;
    twom_nxt      = twom_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    last_nxt      = last_r;

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (fire) begin
      out_valid_nxt = 1'b1;
      col_nxt       = pix_t'($signed({1'b0, center_x})) + pix_t'(cur_x);
      row_nxt       = pix_t'($signed({1'b0, center_y})) - pix_t'(cur_y);
      last_nxt      = is_last;
      if (is_last) begin
        active_nxt = 1'b0;
      end else begin
        left_nxt = left_r - steps_t'(1);
        maj_nxt  = neg_r ? maj_r - coord_t'(1) : maj_r + coord_t'(1);
        if (rem_sum >= twom_ext) begin
          rem_nxt = rem_sum - twom_ext;
          min_nxt = min_r + coord_t'(1);
        end else if (rem_sum < 0) begin
          rem_nxt = rem_sum + twom_ext;
          min_nxt = min_r - coord_t'(1);
        end else begin
          rem_nxt = rem_sum;
        end
      end
    end

    if (pop_en) begin
      active_nxt = 1'b1;
      maj_nxt    = head.desc.major_start;
      min_nxt    = head.desc.minor_start;
      rem_nxt    = rem_t'($signed({1'b0, head.desc.steps}));
      left_nxt   = head.desc.steps;
      xmaj_nxt   = head.desc.x_major;
      neg_nxt    = head.desc.major_neg;
      dmin2_nxt  = head.desc.dminor2;
      twom_nxt   = {head.desc.steps, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    maj_r   <= maj_nxt;
    min_r   <= min_nxt;
    rem_r   <= rem_nxt;
    left_r  <= left_nxt;
    xmaj_r  <= xmaj_nxt;
    neg_r   <= neg_nxt;
    dmin2_r <= dmin2_nxt;
    twom_r  <= twom_nxt;
    col_r   <= col_nxt;
    row_r   <= row_nxt;
    last_r  <= last_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_column = col_r;
  assign out_ch.pixel_row    = row_r;
  assign out_ch.last_pixel   = last_r;

endmodule

### rtl/core/slr_checker.sv
`timescale 1ns / 1ps

module slr_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [7:0] out_col,
  input logic signed [7:0] out_row,
  input logic              out_last
);

  logic [2:0]        pending_r;
  logic              in_seg_r;
  logic signed [7:0] prev_col_r, prev_row_r;
  logic signed [8:0] dcol, drow;
  logic              in_fire, out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign dcol     = 9'(out_col) - 9'(prev_col_r);
  assign drow     = 9'(out_row) - 9'(prev_row_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      in_seg_r  <= 1'b0;
    end else begin
      pending_r <= pending_r + 3'(in_fire) - 3'(out_fire && out_last);
      if (out_fire) begin
        in_seg_r <= !out_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      prev_col_r <= out_col;
      prev_row_r <= out_row;
    end
  end

  // A stalled pixel transaction holds its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_col) && $stable(out_row)
                                && $stable(out_last))
    else $error("pixel changed while stalled");

  // Pixels only appear for a segment that was accepted and not yet finished.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 3'd0)
    else $error("pixel without an outstanding segment");

  // Queue, stepper and output register together hold at most four segments.
  assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 3'd4)
    else $error("too many outstanding segments");

  // Consecutive pixels of one segment are neighbors.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && in_seg_r |-> (dcol == 9'sd0 || dcol == 9'sd1 || dcol == -9'sd1)
                             && (drow == 9'sd0 || drow == 9'sd1 || drow == -9'sd1))
    else $error("pixel step larger than one");

endmodule

bind slope_line_rasterizer slr_checker u_slr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_col   (out_ch.pixel_column),
  .out_row   (out_ch.pixel_row),
  .out_last  (out_ch.last_pixel)
);
